// ===== rtl/tcfq_pkg.sv =====
`timescale 1ns / 1ps
// shared types and codes for the two-class queue with typed dequeue
// no dependencies

package tcfq_pkg;

   localparam int ID_W = 16;

   // operation codes carried on the request side
   typedef enum logic [1:0] {
      FUNC_ENQ   = 2'd0,
      FUNC_ANY   = 2'd1,
      FUNC_KIND0 = 2'd2,
      FUNC_KIND1 = 2'd3
   } func_type;

   // status codes carried on the response side
   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_FULL     = 2'd1,
      ST_REMOVED  = 2'd2,
      ST_NONE     = 2'd3
   } status_type;

   // one stored entry: kind on top, identifier below
   typedef struct packed {
      logic            kind;
      logic [ID_W-1:0] id;
   } entry_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic      shift;    // every cell takes its right neighbor, unless it is the written cell
      logic      wr_en;    // the addressed cell takes wr_data
      entry_type wr_data;
   } cell_cmd_type;

endpackage

// ===== rtl/tcfq_cell.sv =====
`timescale 1ns / 1ps
// one storage cell of the queue chain
// depends on tcfq_pkg for the entry and command types

module tcfq_cell import tcfq_pkg::*; #(
   parameter int IDX   = 0,
   parameter int POS_W = 8
) (
   input  logic             clock,
   input  cell_cmd_type     cmd,
   input  logic [POS_W-1:0] wr_pos,
   input  entry_type        right_q,
   output entry_type        q
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      hit;

   assign hit = cmd.wr_en && (wr_pos == POS_W'(IDX));

   always_comb begin
      entry_in = entry_ff;
      if (hit) begin
         entry_in = cmd.wr_data;
      end else if (cmd.shift) begin
         entry_in = right_q;
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

// ===== rtl/two_class_fifo_oldest_of_kind.sv =====
`timescale 1ns / 1ps
// response: enqueue and dequeue-any register their response as the request word is taken;
//   a typed dequeue goes through the rotate state, then the done state, which waits for a free output register
// throughput: one request at a time; the typed dequeue rotates every stored entry once
//   through the cell chain, one entry per cycle, so the queue's fill sets its length
// reset: clears the fill count, the sequencer and the response valid; cell contents are
//   left as they are and are never read before being written

module two_class_fifo_oldest_of_kind import tcfq_pkg::*; #(
   parameter int CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] animal_id
   input  logic [2:0]  req_tuser,   // [1:0] func, [2] animal_kind
   // response side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] out_id
   output logic [2:0]  rsp_tuser    // [1:0] status, [2] out_kind
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int POS_W = $clog2(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   // sequencer: idle takes requests, rotate walks the chain, done posts the typed result
   typedef enum logic [1:0] {
      S_IDLE,
      S_ROTATE,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;     // entries held
   logic [CNT_W-1:0] rem_ff, rem_in;     // rotation steps left
   logic             found_ff, found_in; // typed match already taken out
   entry_type        hit_ff, hit_in;     // the entry taken out
   logic             want_ff, want_in;   // kind being looked for

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   entry_type        out_ff, out_in;

   cell_cmd_type     cmd;
   logic [POS_W-1:0] wr_pos;
   entry_type        cell_q [CAPACITY];
   entry_type        head;
   entry_type        new_entry;
   logic             req_fire;
   logic             out_free;
   logic             drop;

   // ---------------------------------------------------------------------
   // the chain: cell 0 holds the oldest entry, a shift moves all one step
   // toward cell 0, and the broadcast write lands in the addressed cell
   // ---------------------------------------------------------------------
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      entry_type right_q;
      if (g == CAPACITY - 1) begin : g_last
         assign right_q = '0;
      end else begin : g_mid
         assign right_q = cell_q[g+1];
      end
      tcfq_cell #(
         .IDX   (g),
         .POS_W (POS_W)
      ) u_cell (
         .clock   (clock),
         .cmd     (cmd),
         .wr_pos  (wr_pos),
         .right_q (right_q),
         .q       (cell_q[g])
      );
   end

   assign head          = cell_q[0];
   assign new_entry.id   = req_tdata;
   assign new_entry.kind = req_tuser[2];

   // the output register frees up in the same cycle its word is taken
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;

   // during rotation the first entry of the wanted kind leaving cell 0 is dropped
   assign drop = !found_ff && (head.kind == want_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      found_in     = found_ff;
      hit_in       = hit_ff;
      want_in      = want_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      out_in       = out_ff;
      cmd          = '0;
      wr_pos       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_valid_in = 1'b1;
               out_in       = '0;
               case (func_type'(req_tuser[1:0]))
                  FUNC_ENQ: begin
                     if (cnt_ff == CAP_CNT) begin
                        status_in = ST_FULL;
                     end else begin
                        // append behind the youngest entry
                        cmd.wr_en   = 1'b1;
                        cmd.wr_data = new_entry;
                        wr_pos      = cnt_ff[POS_W-1:0];
                        cnt_in      = cnt_ff + ONE_CNT;
                        status_in   = ST_ENQUEUED;
                     end
                  end
                  FUNC_ANY: begin
                     if (cnt_ff == '0) begin
                        status_in = ST_NONE;
                     end else begin
                        // oldest sits in cell 0; pull the chain forward
                        cmd.shift = 1'b1;
                        cnt_in    = cnt_ff - ONE_CNT;
                        status_in = ST_REMOVED;
                        out_in    = head;
                     end
                  end
                  default: begin
                     // typed dequeue
                     if (cnt_ff == '0) begin
                        status_in = ST_NONE;
                     end else begin
                        rsp_valid_in = rsp_valid_ff && !rsp_tready;
                        state_in     = S_ROTATE;
                        rem_in       = cnt_ff;
                        found_in     = 1'b0;
                        want_in      = req_tuser[0];
                     end
                  end
               endcase
            end
         end

         S_ROTATE: begin
            // head leaves cell 0 and goes back in behind the youngest, unless dropped;
            // after one full turn the order is as before, less the dropped entry
            cmd.shift   = 1'b1;
            cmd.wr_en   = !drop;
            cmd.wr_data = head;
            wr_pos      = POS_W'(cnt_ff - ONE_CNT);
            if (drop) begin
               cnt_in   = cnt_ff - ONE_CNT;
               found_in = 1'b1;
               hit_in   = head;
            end
            rem_in = rem_ff - ONE_CNT;
            if (rem_ff == ONE_CNT) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = found_ff ? ST_REMOVED : ST_NONE;
               out_in       = found_ff ? hit_ff : '0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rem_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rem_ff       <= rem_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hit_ff    <= hit_in;
      want_ff   <= want_in;
      status_ff <= status_in;
      out_ff    <= out_in;
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_tdata      = out_ff.id;
   assign rsp_tuser[1:0] = status_ff;
   assign rsp_tuser[2]   = out_ff.kind;

endmodule
